### rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// types, constants and codes shared by the priority task table modules
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ROW_W    = 48;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_EDIT   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_EXEC   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] user_id;
        logic [15:0] task_id;
        logic [15:0] priority_req;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] exec_user;
    } t_out;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] user_id;
        logic [15:0] prio;
    } t_row;

    typedef struct packed {
        logic             clear;
        logic             sample;
        logic             ent_valid;
        logic [IDX_W-1:0] idx;
    } t_sctl;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [15:0]      hit_user;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             best_found;
        logic [IDX_W-1:0] best_idx;
        logic [15:0]      best_user;
    } t_sres;

endpackage

`default_nettype wire

### rtl/ptt_ram.sv
// ----------------------------------------------------------------------------
// ptt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                              i_wdata,
    input  wire logic                                          i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ptt_search.sv
// ----------------------------------------------------------------------------
// ptt_search
// shared compare unit: tracks id match, first free entry and top entry
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_search (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ptt_pkg::t_sctl i_ctl,
    input  wire ptt_pkg::t_row  i_row,
    input  wire logic [15:0]   i_req_task,
    output ptt_pkg::t_sres     o_res
);

    logic                      r_hit, n_hit;
    logic [ptt_pkg::IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic [15:0]               r_hit_user, n_hit_user;
    logic                      r_free, n_free;
    logic [ptt_pkg::IDX_W-1:0] r_free_idx, n_free_idx;
    logic                      r_best, n_best;
    logic [ptt_pkg::IDX_W-1:0] r_best_idx, n_best_idx;
    logic [15:0]               r_best_user, n_best_user;
    logic [15:0]               r_best_prio, n_best_prio;
    logic [15:0]               r_best_task, n_best_task;
    logic                      w_gt;

    // one magnitude compare on {priority, task id}
    assign w_gt = {i_row.prio, i_row.task_id} > {r_best_prio, r_best_task};

    always_comb begin
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_user  = r_hit_user;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_best_user = r_best_user;
        n_best_prio = r_best_prio;
        n_best_task = r_best_task;
        if (i_ctl.clear) begin
            n_hit  = 1'b0;
            n_free = 1'b0;
            n_best = 1'b0;
        end else if (i_ctl.sample) begin
            if (i_ctl.ent_valid && !r_hit && (i_row.task_id == i_req_task)) begin
                n_hit      = 1'b1;
                n_hit_idx  = i_ctl.idx;
                n_hit_user = i_row.user_id;
            end
            if (!i_ctl.ent_valid && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = i_ctl.idx;
            end
            if (i_ctl.ent_valid && (!r_best || w_gt)) begin
                n_best      = 1'b1;
                n_best_idx  = i_ctl.idx;
                n_best_user = i_row.user_id;
                n_best_prio = i_row.prio;
                n_best_task = i_row.task_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_best <= 1'b0;
        end else begin
            r_hit  <= n_hit;
            r_free <= n_free;
            r_best <= n_best;
        end
        r_hit_idx   <= n_hit_idx;
        r_hit_user  <= n_hit_user;
        r_free_idx  <= n_free_idx;
        r_best_idx  <= n_best_idx;
        r_best_user <= n_best_user;
        r_best_prio <= n_best_prio;
        r_best_task <= n_best_task;
    end

    always_comb begin
        o_res.hit        = r_hit;
        o_res.hit_idx    = r_hit_idx;
        o_res.hit_user   = r_hit_user;
        o_res.free_found = r_free;
        o_res.free_idx   = r_free_idx;
        o_res.best_found = r_best;
        o_res.best_idx   = r_best_idx;
        o_res.best_user  = r_best_user;
    end

endmodule

`default_nettype wire

### rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl
// request sequencer: scan counter, valid bits, table update and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire ptt_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output ptt_pkg::t_out       o_out_data,
    input  wire ptt_pkg::t_sres i_sres,
    output ptt_pkg::t_sctl      o_sctl,
    output logic [15:0]         o_req_task,
    output logic                o_ram_re,
    output logic [ptt_pkg::IDX_W-1:0] o_ram_raddr,
    output logic                o_ram_we,
    output logic [ptt_pkg::IDX_W-1:0] o_ram_waddr,
    output ptt_pkg::t_row       o_ram_wdata
);

    ptt_pkg::t_state               r_state, n_state;
    logic [ptt_pkg::CNT_W-1:0]     r_cnt;
    logic                          r_rd_pend;
    logic [ptt_pkg::IDX_W-1:0]     r_rd_idx;
    ptt_pkg::t_in                  r_req;
    logic [ptt_pkg::CAPACITY-1:0]  r_valid, n_valid;
    logic                          r_out_vld;
    ptt_pkg::t_out                 r_out, n_out;
    logic                          w_accept;
    logic                          w_fin;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ptt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ptt_pkg::S_SCAN;
                end
            end
            ptt_pkg::S_SCAN: begin
                if (r_cnt == ptt_pkg::CNT_W'(ptt_pkg::CAPACITY - 1)) begin
                    n_state = ptt_pkg::S_DRAIN;
                end
            end
            ptt_pkg::S_DRAIN: begin
                n_state = ptt_pkg::S_FINISH;
            end
            ptt_pkg::S_FINISH: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = ptt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == ptt_pkg::S_IDLE);
        o_ram_re         = (r_state == ptt_pkg::S_SCAN);
        o_ram_raddr      = r_cnt[ptt_pkg::IDX_W-1:0];
        o_sctl.clear     = w_accept;
        o_sctl.sample    = r_rd_pend;
        o_sctl.ent_valid = r_valid[r_rd_idx];
        o_sctl.idx       = r_rd_idx;
        o_req_task       = r_req.task_id;
        w_fin            = (r_state == ptt_pkg::S_FINISH) && (!r_out_vld || i_out_ready);

        o_ram_we              = 1'b0;
        o_ram_waddr           = i_sres.hit_idx;
        o_ram_wdata.task_id   = r_req.task_id;
        o_ram_wdata.user_id   = r_req.user_id;
        o_ram_wdata.prio      = r_req.priority_req;
        n_valid               = r_valid;
        n_out.status          = ptt_pkg::STAT_DONE;
        n_out.exec_user       = 16'd0;

        case (r_req.req_type)
            ptt_pkg::REQ_ADD: begin
                if (i_sres.hit) begin
                    o_ram_we = w_fin;
                end else if (i_sres.free_found) begin
                    o_ram_we    = w_fin;
                    o_ram_waddr = i_sres.free_idx;
                    n_valid[i_sres.free_idx] = 1'b1;
                end else begin
                    n_out.status = ptt_pkg::STAT_FULL;
                end
            end
            ptt_pkg::REQ_EDIT: begin
                o_ram_wdata.user_id = i_sres.hit_user;
                if (i_sres.hit) begin
                    o_ram_we = w_fin;
                end else begin
                    n_out.status = ptt_pkg::STAT_MISSING;
                end
            end
            ptt_pkg::REQ_REMOVE: begin
                if (i_sres.hit) begin
                    n_valid[i_sres.hit_idx] = 1'b0;
                end else begin
                    n_out.status = ptt_pkg::STAT_MISSING;
                end
            end
            default: begin
                if (i_sres.best_found) begin
                    n_out.exec_user = i_sres.best_user;
                    n_valid[i_sres.best_idx] = 1'b0;
                end else begin
                    n_out.status = ptt_pkg::STAT_MISSING;
                end
            end
        endcase

        o_out_valid = r_out_vld;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ptt_pkg::S_IDLE;
            r_cnt     <= '0;
            r_rd_pend <= 1'b0;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == ptt_pkg::S_SCAN);
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ptt_pkg::S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_fin) begin
                r_valid   <= n_valid;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
        r_rd_idx <= r_cnt[ptt_pkg::IDX_W-1:0];
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_fin) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### rtl/priority_task_table_top.sv
// ----------------------------------------------------------------------------
// priority_task_table_top
// table of tasks with add, edit, remove and execute-highest-priority requests
// ----------------------------------------------------------------------------
// input channel i_in_valid / o_in_ready carries one request transaction
// (req_type, user_id, task_id, priority_req); output channel o_out_valid /
// i_out_ready returns exactly one status transaction per request
// every request walks all CAPACITY table rows through one ram read port and
// one shared compare unit, one row per cycle; after the walk a drain state
// lets the last registered read be compared, then the update step updates
// the table and loads the result register, and only then is the next
// request taken, so requests never overlap in the table walk
// the result sits in an output register; the next request is accepted
// while it waits, but that request's update step holds until the old
// result is taken
// reset clears all valid bits at once, so the table starts empty and no
// clearing pass is needed; row contents are only read behind a valid bit
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_table_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ptt_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ptt_pkg::t_out      o_out_data
);

    ptt_pkg::t_sctl            w_sctl;
    ptt_pkg::t_sres            w_sres;
    logic [15:0]               w_req_task;
    logic                      w_ram_re;
    logic [ptt_pkg::IDX_W-1:0] w_ram_raddr;
    logic                      w_ram_we;
    logic [ptt_pkg::IDX_W-1:0] w_ram_waddr;
    ptt_pkg::t_row             w_ram_wdata;
    logic [ptt_pkg::ROW_W-1:0] w_ram_rdata;
    ptt_pkg::t_row             w_row;

    assign w_row = w_ram_rdata;

    ptt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_sres      (w_sres),
        .o_sctl      (w_sctl),
        .o_req_task  (w_req_task),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata)
    );

    ptt_ram #(
        .WIDTH (ptt_pkg::ROW_W),
        .DEPTH (ptt_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    ptt_search u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_sctl),
        .i_row      (w_row),
        .i_req_task (w_req_task),
        .o_res      (w_sres)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while a request is in flight");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> !o_in_ready)
        else $error("table write while idle");

    a_clear_not_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sctl.clear && w_sctl.sample))
        else $error("search cleared while sampling a row");

    a_read_before_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_re |=> w_sctl.sample)
        else $error("row read without a compare step");

endmodule

`default_nettype wire
